// File: sv/tsd_pkg.sv
// tsd_pkg: shared constants and types for the tar stream deframer.
// No dependencies; imported by the deframer and its port checker.
`default_nettype none

package tsd_pkg;

    // Archive block geometry (ustar layout)
    localparam int BLOCK_BYTES = 512;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int NAME_BYTES  = 100;
    localparam int SIZE_OFFSET = 124;
    localparam int SIZE_DIGITS = 12;
    localparam int SIZE_W      = 36;
    localparam int BYTE_W      = 8;

    // Output tdata: byte value, then file size, padded to whole bytes
    localparam int TDATA_BITS  = BYTE_W + SIZE_W;
    localparam int TDATA_W     = ((TDATA_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;

    // Result kinds, carried on tuser
    typedef enum logic [1:0] {
        KIND_NAME     = 2'd0,
        KIND_HDR_DONE = 2'd1,
        KIND_DATA     = 2'd2,
        KIND_EOA      = 2'd3
    } t_kind;

endpackage

`default_nettype wire

// File: sv/tar_stream_deframer.sv
// tar_stream_deframer: splits a tar byte stream into name bytes, header reports,
// file data bytes and an end-of-archive mark. Depends on tsd_pkg.
`default_nettype none

// Usage
//   Slave stream (s_*): one archive byte per item in s_tdata, 512-byte blocks.
//   Master stream (m_*): one result item per byte that produces one:
//     tuser = kind (name byte, header done, data byte, end of archive),
//     tdata = {pad, file_size[35:0], byte_value[7:0]}, tlast = last data byte.
//   Name bytes come out up to the first NUL (max 100). At the last header byte
//   a header-done item reports the octal size decoded from offsets 124..135,
//   or an end-of-archive item if the whole block was zero. Then exactly size
//   data bytes follow, the last with tlast; padding bytes give no item.
//   After end of archive every byte is taken and dropped until reset.
// Timing
//   Throughput: one byte per clock while the receiver keeps up. All decode
//   runs in the cycle a byte is taken; the result is registered into the
//   output register for the next cycle. s_tready is high when the output
//   register is empty or is being drained this cycle, so a stalled receiver
//   holds the result and backs up the input after one item.
// Reset
//   i_rst_n low (synchronous) returns to header phase at block offset 0 and
//   empties the output register.

module tar_stream_deframer
    import tsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input stream
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    output      logic [TDATA_W-1:0] m_tdata,   // [7:0] byte_value, [43:8] file_size, rest 0
    output      logic [1:0]         m_tuser,   // [1:0] kind
    output      logic               m_tlast    // last_of_file
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_PAD    = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    localparam logic [OFF_W-1:0] OFF_LAST   = OFF_W'(BLOCK_BYTES - 1);
    localparam logic [OFF_W-1:0] OFF_NAME   = OFF_W'(NAME_BYTES);
    localparam logic [OFF_W-1:0] OFF_SIZE_LO = OFF_W'(SIZE_OFFSET);
    localparam logic [OFF_W-1:0] OFF_SIZE_HI = OFF_W'(SIZE_OFFSET + SIZE_DIGITS);

    // control state
    t_phase              r_phase,   n_phase;
    logic [OFF_W-1:0]    r_offset,  n_offset;
    logic [SIZE_W-1:0]   r_size,    n_size;
    logic                r_size_end, n_size_end;
    logic                r_name_end, n_name_end;
    logic                r_all_zero, n_all_zero;
    logic [SIZE_W-1:0]   r_left,    n_left;

    // output register
    logic                r_out_valid, n_out_valid;
    t_kind               r_kind,    n_kind;
    logic [BYTE_W-1:0]   r_byte,    n_byte;
    logic [SIZE_W-1:0]   r_fsize,   n_fsize;
    logic                r_last,    n_last;

    logic                accept;
    logic                block_end;
    logic                in_size_field;
    logic                is_octal;
    logic                emit;

    assign s_tready  = !r_out_valid || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign block_end = (r_offset == OFF_LAST);
    assign in_size_field = (r_offset >= OFF_SIZE_LO) && (r_offset < OFF_SIZE_HI);
    assign is_octal  = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_SEVEN);

    always_comb begin
        n_phase    = r_phase;
        n_offset   = r_offset;
        n_size     = r_size;
        n_size_end = r_size_end;
        n_name_end = r_name_end;
        n_all_zero = r_all_zero;
        n_left     = r_left;
        emit       = 1'b0;
        n_kind     = r_kind;
        n_byte     = r_byte;
        n_fsize    = r_fsize;
        n_last     = r_last;

        if (accept && r_phase != PH_DONE) begin
            n_offset = block_end ? '0 : r_offset + OFF_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (s_tdata != '0) n_all_zero = 1'b0;
                    if (r_offset < OFF_NAME && !r_name_end) begin
                        if (s_tdata == '0) begin
                            n_name_end = 1'b1;
                        end else begin
                            emit    = 1'b1;
                            n_kind  = KIND_NAME;
                            n_byte  = s_tdata;
                            n_fsize = '0;
                            n_last  = 1'b0;
                        end
                    end
                    if (in_size_field && !r_size_end) begin
                        if (s_tdata == '0) begin
                            n_size_end = 1'b1;
                        end else if (is_octal) begin
                            // shift in one octal digit, modulo 2^36
                            n_size = {r_size[SIZE_W-4:0], s_tdata[2:0]};
                        end
                    end
                    if (block_end) begin
                        emit   = 1'b1;
                        n_byte = '0;
                        n_last = 1'b0;
                        if (n_all_zero) begin
                            n_kind  = KIND_EOA;
                            n_fsize = '0;
                            n_phase = PH_DONE;
                        end else begin
                            n_kind  = KIND_HDR_DONE;
                            n_fsize = r_size;
                            n_left  = r_size;
                            n_phase = (r_size != '0) ? PH_DATA : PH_HEADER;
                        end
                        n_size     = '0;
                        n_size_end = 1'b0;
                        n_name_end = 1'b0;
                        n_all_zero = 1'b1;
                    end
                end
                PH_DATA: begin
                    n_left  = r_left - SIZE_W'(1);
                    emit    = 1'b1;
                    n_kind  = KIND_DATA;
                    n_byte  = s_tdata;
                    n_fsize = '0;
                    n_last  = (r_left == SIZE_W'(1));
                    if (r_left == SIZE_W'(1)) begin
                        n_phase = block_end ? PH_HEADER : PH_PAD;
                    end
                end
                PH_PAD: begin
                    if (block_end) n_phase = PH_HEADER;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (accept) begin
            n_out_valid = emit;
        end else if (m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_offset    <= '0;
            r_size      <= '0;
            r_size_end  <= 1'b0;
            r_name_end  <= 1'b0;
            r_all_zero  <= 1'b1;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_size      <= n_size;
            r_size_end  <= n_size_end;
            r_name_end  <= n_name_end;
            r_all_zero  <= n_all_zero;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        // payload needs no reset
        if (accept && emit) begin
            r_kind  <= n_kind;
            r_byte  <= n_byte;
            r_fsize <= n_fsize;
            r_last  <= n_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_kind;
    assign m_tlast  = r_last;
    assign m_tdata  = TDATA_W'({r_fsize, r_byte});

endmodule

`default_nettype wire

// File: sv/tsd_checker.sv
// tsd_checker: port-level assertions for tar_stream_deframer, bound to it below.
// Depends on tsd_pkg and the deframer's port list.
`default_nettype none

module tsd_checker
    import tsd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [BYTE_W-1:0]  s_tdata,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [1:0]         m_tuser,
    input wire logic               m_tlast
);

    // a stalled result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // tlast only marks file data
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser == KIND_DATA)
        else $error("tlast on non-data item");

    // header-done and end items carry no byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == KIND_HDR_DONE || m_tuser == KIND_EOA)
            |-> m_tdata[BYTE_W-1:0] == '0)
        else $error("byte value on header/end item");

    // size only on header-done
    a_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != KIND_HDR_DONE |-> m_tdata[TDATA_BITS-1:BYTE_W] == '0)
        else $error("file size outside header-done item");

    // input backs up only behind a full, stalled output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind tar_stream_deframer tsd_checker u_tsd_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for tar_stream_deframer, driven by whole tar members.
// Needs tsd_pkg and the deframer RTL; results are checked item by item
// against a byte-level deframer model kept in this file.
`timescale 1ns / 100ps

module tb_top;
    import tsd_pkg::*;

    localparam int QUIET_LIMIT   = 5000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES  = 16;    // slack after the queues drain
    localparam int ITEMS         = 1600;  // rough number of archive bytes sent
    localparam int PHASE_ITEMS   = ITEMS / 3;
    localparam int DIR_ROWS      = 1;

    // How a header's 12-byte size field is written
    typedef enum logic [1:0] {
        SZ_STD,    // 11 octal digits then NUL
        SZ_FULL,   // 12 octal digits, no NUL
        SZ_NOISY,  // digits mixed with non-octal chars, maybe NUL then garbage
        SZ_EMPTY   // all zero
    } t_size_fmt;

    typedef enum logic [1:0] {ARC_HEADER, ARC_DATA, ARC_PAD, ARC_DONE} t_arc_phase;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] val;
        logic [SIZE_W-1:0] size;
        logic              last;
    } t_arc_res;

    // One archive byte to send; typed marks a header end whose size is given by the plan
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        bit                typed;
        logic [SIZE_W-1:0] typed_size;
    } t_arc_byte;

    typedef struct packed {
        int                name_len;   // NAME_BYTES means no NUL in the name field
        logic [BYTE_W-1:0] name_fill;  // 0: random nonzero name bytes
        logic [SIZE_W-1:0] size;       // also the size the header item must report
        t_size_fmt         fmt;
        bit                noisy;      // random bytes outside name and size fields
        int                mark_off;   // one nonzero byte here, -1 for none
    } t_member_row;

    // Directed members; the header-done size of each is the size column
    t_member_row dir_plan [DIR_ROWS] = '{
        '{NAME_BYTES, 8'h01, 36'd0,    SZ_NOISY, 1'b1, -1}    // name without NUL, zero size
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;    // [7:0] byte_value, [43:8] file_size, rest 0
    logic [1:0]         m_tuser;    // [1:0] kind
    logic               m_tlast;

    tar_stream_deframer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 i_clk = ~i_clk;

    t_arc_byte arc_feed [$];     // bytes still to send, head is on the bus
    t_arc_res  pending_res [$];  // results predicted but not yet seen
    int        src_idle = 12;    // percent of cycles the sender holds off
    int        dst_idle = 87;    // percent of cycles the receiver stalls
    int        n_in = 0;
    int        n_bad = 0;
    int        n_res = 0;
    int        quiet = 0;

    // Deframer model state
    t_arc_phase        arc_phase = ARC_HEADER;
    logic [OFF_W-1:0]  blk_off = '0;
    logic [SIZE_W-1:0] size_acc = '0;
    logic [SIZE_W-1:0] bytes_left = '0;
    bit                size_seen_nul = 1'b0;
    bit                name_seen_nul = 1'b0;
    bit                hdr_all_zero = 1'b1;

    // Advance the model by one archive byte; returns 1 when the byte yields an item
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_arc_res r);
        logic [OFF_W-1:0] off;
        bit               blk_end;
        bit               got;
        off     = blk_off;
        blk_end = (off == BLOCK_BYTES - 1);
        got     = 1'b0;
        r       = '{KIND_NAME, 8'h00, '0, 1'b0};
        if (arc_phase == ARC_DONE)
            return 1'b0;
        blk_off = blk_end ? '0 : off + 1'b1;
        case (arc_phase)
            ARC_HEADER: begin
                if (b != 0)
                    hdr_all_zero = 1'b0;
                if (off < NAME_BYTES && !name_seen_nul) begin
                    if (b == 0)
                        name_seen_nul = 1'b1;
                    else begin
                        r   = '{KIND_NAME, b, '0, 1'b0};
                        got = 1'b1;
                    end
                end
                if (off >= SIZE_OFFSET && off < SIZE_OFFSET + SIZE_DIGITS && !size_seen_nul) begin
                    if (b == 0)
                        size_seen_nul = 1'b1;
                    else if (b >= CHAR_ZERO && b <= CHAR_SEVEN)
                        size_acc = (size_acc << 3) + SIZE_W'(b - CHAR_ZERO);
                end
                if (blk_end) begin
                    if (hdr_all_zero) begin
                        r         = '{KIND_EOA, 8'h00, '0, 1'b0};
                        arc_phase = ARC_DONE;
                    end else begin
                        r          = '{KIND_HDR_DONE, 8'h00, size_acc, 1'b0};
                        bytes_left = size_acc;
                        arc_phase  = (size_acc != 0) ? ARC_DATA : ARC_HEADER;
                    end
                    got           = 1'b1;
                    size_acc      = '0;
                    size_seen_nul = 1'b0;
                    name_seen_nul = 1'b0;
                    hdr_all_zero  = 1'b1;
                end
            end
            ARC_DATA: begin
                bytes_left = bytes_left - 1'b1;
                r   = '{KIND_DATA, b, '0, bytes_left == 0};
                got = 1'b1;
                if (bytes_left == 0)
                    arc_phase = blk_end ? ARC_HEADER : ARC_PAD;
            end
            default: begin
                if (blk_end)
                    arc_phase = ARC_HEADER;
            end
        endcase
        return got;
    endfunction

    function automatic logic [BYTE_W-1:0] junk_char();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255, 1));
        while (b >= CHAR_ZERO && b <= CHAR_SEVEN);
        return b;
    endfunction

    task automatic push_raw(input logic [BYTE_W-1:0] b);
        t_arc_byte f;
        f = '{b, 1'b0, '0};
        arc_feed.push_back(f);
    endtask

    // One 512-byte header block
    task automatic put_header(input int name_len, input logic [BYTE_W-1:0] fill,
                              input logic [SIZE_W-1:0] size, input t_size_fmt fmt,
                              input bit noisy, input int mark_off, input bit typed);
        logic [BYTE_W-1:0] blk [BLOCK_BYTES];
        logic [SIZE_W-1:0] v;
        int                nd;
        int                dleft;
        bit                ended;
        t_arc_byte         f;
        for (int i = 0; i < BLOCK_BYTES; i++)
            blk[i] = noisy ? BYTE_W'($urandom) : 8'h00;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (i < name_len)
                blk[i] = (fill != 0) ? fill : BYTE_W'($urandom_range(255, 1));
            else if (i == name_len)
                blk[i] = 8'h00;
        end
        case (fmt)
            SZ_STD: begin
                for (int i = 0; i < SIZE_DIGITS - 1; i++)
                    blk[SIZE_OFFSET + i] =
                        CHAR_ZERO + BYTE_W'((size >> (3 * (SIZE_DIGITS - 2 - i))) & 7);
                blk[SIZE_OFFSET + SIZE_DIGITS - 1] = 8'h00;
            end
            SZ_FULL: begin
                for (int i = 0; i < SIZE_DIGITS; i++)
                    blk[SIZE_OFFSET + i] =
                        CHAR_ZERO + BYTE_W'((size >> (3 * (SIZE_DIGITS - 1 - i))) & 7);
            end
            SZ_EMPTY: begin
                for (int i = 0; i < SIZE_DIGITS; i++)
                    blk[SIZE_OFFSET + i] = 8'h00;
            end
            default: begin
                // leading zeros and junk are skipped, anything after a NUL is ignored
                nd = 0;
                for (v = size; v != 0; v = v >> 3)
                    nd++;
                dleft = $urandom_range(SIZE_DIGITS, nd);
                ended = 1'b0;
                for (int p = 0; p < SIZE_DIGITS; p++) begin
                    if (dleft == 0) begin
                        if (ended)
                            blk[SIZE_OFFSET + p] = BYTE_W'($urandom);
                        else if ($urandom_range(1) == 1) begin
                            blk[SIZE_OFFSET + p] = 8'h00;
                            ended = 1'b1;
                        end else
                            blk[SIZE_OFFSET + p] = junk_char();
                    end else if (SIZE_DIGITS - p > dleft && $urandom_range(2) == 0)
                        blk[SIZE_OFFSET + p] = junk_char();
                    else begin
                        dleft--;
                        blk[SIZE_OFFSET + p] = CHAR_ZERO + BYTE_W'((size >> (3 * dleft)) & 7);
                    end
                end
            end
        endcase
        if (mark_off >= 0)
            blk[mark_off] = BYTE_W'($urandom_range(255, 1));
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            f = '{blk[i], typed && (i == BLOCK_BYTES - 1), size};
            arc_feed.push_back(f);
        end
    endtask

    // Member data plus padding up to the block edge
    task automatic put_data(input int size);
        for (int i = 0; i < size; i++)
            push_raw(BYTE_W'($urandom));
        if (size % BLOCK_BYTES != 0)
            for (int i = size % BLOCK_BYTES; i < BLOCK_BYTES; i++)
                push_raw(BYTE_W'($urandom));
    endtask

    task automatic put_random_member();
        int        nl;
        int        sz;
        int        pick;
        int        mark;
        t_size_fmt fmt;
        bit        noisy;
        pick = $urandom_range(99);
        nl   = (pick < 15) ? 0 : (pick < 30) ? NAME_BYTES : $urandom_range(NAME_BYTES - 1, 1);
        pick = $urandom_range(99);
        // data stays within one block to keep the run short
        if (pick < 15)
            sz = 0;
        else if (pick < 65)
            sz = $urandom_range(40, 1);
        else if (pick < 90)
            sz = $urandom_range(BLOCK_BYTES - 1, 41);
        else
            sz = BLOCK_BYTES;
        pick  = $urandom_range(99);
        fmt   = (pick < 45) ? SZ_STD : (pick < 70) ? SZ_FULL : SZ_NOISY;
        noisy = ($urandom_range(99) < 30);
        // a header that might come out all zero would end the archive early
        mark  = (nl == 0 && sz == 0 && fmt == SZ_NOISY && !noisy) ?
                $urandom_range(BLOCK_BYTES - 1, SIZE_OFFSET + SIZE_DIGITS) : -1;
        put_header(nl, 8'h00, SIZE_W'(sz), fmt, noisy, mark, 1'b0);
        put_data(sz);
    endtask

    // Sender holds off until everything sent has come out
    task automatic drain();
        while (arc_feed.size() != 0 || pending_res.size() != 0)
            @(negedge i_clk);
    endtask

    // Bus driver, predictor hookup and result check
    always @(posedge i_clk) begin : bus
        t_arc_byte cur;
        t_arc_res  want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                n_res++;
                if (pending_res.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("item %0d unexpected: kind %0d byte %h size %0d last %b",
                                 n_res, m_tuser, m_tdata[BYTE_W-1:0],
                                 m_tdata[BYTE_W+:SIZE_W], m_tlast);
                end else begin
                    want = pending_res.pop_front();
                    if (m_tuser !== want.kind || m_tlast !== want.last ||
                        m_tdata !== {{(TDATA_W - TDATA_BITS){1'b0}}, want.size, want.val}) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"item %0d mismatch (exp/got): kind %0d/%0d byte %h/%h ",
                                      "size %0d/%0d last %b/%b tdata %h"},
                                     n_res, want.kind, m_tuser, want.val, m_tdata[BYTE_W-1:0],
                                     want.size, m_tdata[BYTE_W+:SIZE_W], want.last, m_tlast,
                                     m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_in++;
                cur = arc_feed.pop_front();
                if (deframe_byte(s_tdata, want)) begin
                    if (cur.typed)
                        want = '{KIND_HDR_DONE, 8'h00, cur.typed_size, 1'b0};
                    pending_res.push_back(want);
                end
            end
            // sender idles lightly, then receiver, then nobody
            src_idle = (n_in < PHASE_ITEMS) ? 12 : (n_in < 2 * PHASE_ITEMS) ? 87 : 0;
            dst_idle = (n_in < PHASE_ITEMS) ? 87 : (n_in < 2 * PHASE_ITEMS) ? 12 : 0;
            if (!s_tvalid || s_tready) begin
                if (arc_feed.size() != 0 && $urandom_range(99) >= src_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= arc_feed[0].data;
                end else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= dst_idle);
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed members
        foreach (dir_plan[r]) begin
            put_header(dir_plan[r].name_len, dir_plan[r].name_fill, dir_plan[r].size,
                       dir_plan[r].fmt, dir_plan[r].noisy, dir_plan[r].mark_off, 1'b1);
            put_data(int'(dir_plan[r].size));
        end
        drain();

        // random member
        put_random_member();

        // end of archive, then junk that must be dropped
        for (int i = 0; i < BLOCK_BYTES; i++)
            push_raw(8'h00);
        for (int i = 0; i < 32; i++)
            push_raw(BYTE_W'($urandom));
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_bad == 0 && pending_res.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
